// ===== design/kbv_pkg.sv =====
// shared constants, types and state codes for the knapsack best value block
package kbv_pkg;

    localparam int MAX_CAPACITY = 1023;
    localparam int ROW_DEPTH    = MAX_CAPACITY + 1;
    localparam int ROW_AW       = $clog2(ROW_DEPTH);

    localparam int CAP_W    = 10;
    localparam int WEIGHT_W = 10;
    localparam int VALUE_W  = 16;
    localparam int TOTAL_W  = 32;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_OUT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] addr;
        logic [TOTAL_W-1:0] data;
    } wr_req_t;

endpackage

// ===== design/kbv_row_ram.sv =====
// row of best totals: one write port, two registered read ports
module kbv_row_ram (
    input  logic                          aclk,
    input  kbv_pkg::wr_req_t              wr,
    input  logic [kbv_pkg::ROW_AW-1:0]    rd_a_addr,
    input  logic [kbv_pkg::ROW_AW-1:0]    rd_b_addr,
    output logic [kbv_pkg::TOTAL_W-1:0]   rd_a_data,
    output logic [kbv_pkg::TOTAL_W-1:0]   rd_b_data
);

    logic [kbv_pkg::TOTAL_W-1:0] mem [kbv_pkg::ROW_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ===== design/knapsack_best_value.sv =====
// top level of the 0/1 knapsack best value solver
//
// items enter on the s_ channel: tdata holds weight and value, tlast marks
// the final item of a set. the user must see that the capacity register is
// written through cfg_wr_en / cfg_wr_data only while the block is idle; the
// block itself does not enforce this. each item sweeps the row of best
// totals from the capacity down to 1, one entry per cycle through a
// read-modify-write pipeline on the row memory, and the next item is taken
// once the pipeline has drained (there is no sweep when capacity is 0).
// on the item marked last the best total at full capacity passes through
// the drain and read steps to an output register on the m_ channel, and the
// row is then cleared one entry per cycle over all 1024 entries before the
// next item. after reset the same clearing pass runs with s_tready low;
// configuration writes are taken at any time.
// while the receiver stalls the result holds in the output register; a
// further last item waits at the result step until the register is free.
module knapsack_best_value (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kbv_pkg::CAP_W-1:0]       cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kbv_pkg::S_DATA_W-1:0]    s_tdata,    // item_weight, item_value
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kbv_pkg::M_DATA_W-1:0]    m_tdata     // best_total
);

    localparam int AW = kbv_pkg::ROW_AW;
    localparam int TW = kbv_pkg::TOTAL_W;
    localparam int WW = kbv_pkg::WEIGHT_W;
    localparam int VW = kbv_pkg::VALUE_W;

    kbv_pkg::state_t state_reg, state_next;
    logic [kbv_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [AW-1:0] limit_reg, limit_next;
    logic [AW-1:0] sweep_c_reg, sweep_c_next;
    logic [AW-1:0] clr_c_reg, clr_c_next;
    logic [WW-1:0] weight_reg, weight_next;
    logic [VW-1:0] value_reg, value_next;
    logic last_reg, last_next;
    logic s1_valid_reg, s1_valid_next;
    logic s1_upd_reg, s1_upd_next;
    logic [AW-1:0] s1_addr_reg, s1_addr_next;
    kbv_pkg::wr_req_t wr_reg, wr_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [TW-1:0] m_tdata_reg, m_tdata_next;

    kbv_pkg::wr_req_t ram_wr;
    logic [AW-1:0] rd_a_addr, rd_b_addr;
    logic [TW-1:0] rd_a_data, rd_b_data;

    logic [31:0] cap_ext, sweep_ext, weight_ext;
    logic [AW-1:0] cap_limit;
    logic sweep_upd;
    logic [TW:0] take_sum;
    logic [TW-1:0] take;

    kbv_row_ram u_row_ram (
        .aclk      (aclk),
        .wr        (ram_wr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    assign cap_ext    = 32'(cap_reg);
    assign cap_limit  = (cap_ext > 32'(kbv_pkg::MAX_CAPACITY)) ?
                        AW'(kbv_pkg::MAX_CAPACITY) : AW'(cap_ext);
    assign sweep_ext  = 32'(sweep_c_reg);
    assign weight_ext = 32'(weight_reg);
    assign sweep_upd  = (weight_ext <= sweep_ext);

    assign take_sum = {1'b0, rd_b_data} + (TW + 1)'(value_reg);
    assign take     = take_sum[TW] ? {TW{1'b1}} : take_sum[TW-1:0];

    assign s_tready = (state_reg == kbv_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        if (state_reg == kbv_pkg::ST_SWEEP) begin
            rd_a_addr = sweep_c_reg;
            rd_b_addr = sweep_upd ? AW'(sweep_ext - weight_ext) : sweep_c_reg;
        end else begin
            rd_a_addr = limit_reg;
            rd_b_addr = limit_reg;
        end
        if (state_reg == kbv_pkg::ST_CLEAR) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_c_reg;
            ram_wr.data = '0;
        end else begin
            ram_wr = wr_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cap_next      = cfg_wr_en ? cfg_wr_data : cap_reg;
        limit_next    = limit_reg;
        sweep_c_next  = sweep_c_reg;
        clr_c_next    = clr_c_reg;
        weight_next   = weight_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        s1_valid_next = 1'b0;
        s1_upd_next   = sweep_upd;
        s1_addr_next  = sweep_c_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        wr_next.en   = s1_valid_reg && s1_upd_reg && (take > rd_a_data);
        wr_next.addr = s1_addr_reg;
        wr_next.data = take;

        case (state_reg)
            kbv_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    weight_next  = s_tdata[WW-1:0];
                    value_next   = s_tdata[WW+VW-1:WW];
                    last_next    = s_tlast;
                    limit_next   = cap_limit;
                    sweep_c_next = cap_limit;
                    state_next   = (cap_limit == '0) ? kbv_pkg::ST_DRAIN : kbv_pkg::ST_SWEEP;
                end
            end
            kbv_pkg::ST_SWEEP: begin
                s1_valid_next = 1'b1;
                if (sweep_c_reg == AW'(1)) begin
                    state_next = kbv_pkg::ST_DRAIN;
                end else begin
                    sweep_c_next = sweep_c_reg - AW'(1);
                end
            end
            kbv_pkg::ST_DRAIN: begin
                if (!s1_valid_reg && !wr_reg.en) begin
                    state_next = last_reg ? kbv_pkg::ST_READ : kbv_pkg::ST_IDLE;
                end
            end
            kbv_pkg::ST_READ: begin
                state_next = kbv_pkg::ST_OUT;
            end
            kbv_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rd_a_data;
                    clr_c_next    = '0;
                    state_next    = kbv_pkg::ST_CLEAR;
                end
            end
            kbv_pkg::ST_CLEAR: begin
                if (clr_c_reg == AW'(kbv_pkg::ROW_DEPTH - 1)) begin
                    state_next = kbv_pkg::ST_IDLE;
                end else begin
                    clr_c_next = clr_c_reg + AW'(1);
                end
            end
            default: begin
                state_next = kbv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kbv_pkg::ST_CLEAR;
            cap_reg      <= '0;
            clr_c_reg    <= '0;
            s1_valid_reg <= 1'b0;
            wr_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            clr_c_reg    <= clr_c_next;
            s1_valid_reg <= s1_valid_next;
            wr_reg       <= wr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg    <= limit_next;
        sweep_c_reg  <= sweep_c_next;
        weight_reg   <= weight_next;
        value_reg    <= value_next;
        last_reg     <= last_next;
        s1_upd_reg   <= s1_upd_next;
        s1_addr_reg  <= s1_addr_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // pending write-back always lands above the entry being read
    a_wr_above_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kbv_pkg::ST_SWEEP && wr_reg.en) |-> (wr_reg.addr > sweep_c_reg))
        else $error("write-back overlaps sweep read");

    // sweep index stays within 1..limit
    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kbv_pkg::ST_SWEEP) |-> (sweep_c_reg != '0 && sweep_c_reg <= limit_reg))
        else $error("sweep index out of range");

    // no row write while idle
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kbv_pkg::ST_IDLE) |-> !ram_wr.en)
        else $error("row written while idle");

    // a new result is always followed by the clearing pass
    a_result_then_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kbv_pkg::ST_OUT && state_next == kbv_pkg::ST_CLEAR)
        |=> (m_tvalid_reg && clr_c_reg == '0))
        else $error("result not followed by clear");

endmodule
